>>> src/dctd_pkg.sv
// ----------------------------------------------------------------------------
// Divisor counter package
// Shared widths, types and helpers for the trial-division divisor counter.
// ----------------------------------------------------------------------------
package dctd_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned COUNT_W    = 11;
	localparam int unsigned EXP_BITS   = $clog2(VALUE_BITS + 1);
	localparam int unsigned STEP_BITS  = $clog2(VALUE_BITS + 1);
	localparam int unsigned PROD_W     = COUNT_W + EXP_BITS;

	typedef logic [VALUE_BITS-1:0] word_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [EXP_BITS-1:0]   exp_t;

	localparam count_t COUNT_MAX = '1;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t quotient;
		word_t remainder;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	function automatic count_t sat_mul(count_t a, exp_t b);
		logic [PROD_W-1:0] p;
		p = PROD_W'(a) * PROD_W'(b);
		if (p > PROD_W'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return count_t'(p);
	endfunction

endpackage

>>> src/divisor_count_trial_division.sv
// ----------------------------------------------------------------------------
// Divisor counter by trial division
// Counts the positive divisors of an unsigned value by factoring it with
// trial divisors from 2 upward and one shared bit-serial divider.
//
//   Channel   Handshake                 Payload
//   input     value_valid/value_stall   value         (32 bits)
//   output    count_valid/count_stall   divisor_count (11 bits)
//
// The shared divider resolves each trial division one bit a cycle.
// A transaction runs trial divisions until the trial divisor exceeds the
// quotient; a zero value skips the divider and goes straight to the result.
// The block takes no new transaction until the current result is registered.
// The result register holds while count_valid and count_stall are both high.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module divisor_count_trial_division (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_stall,
	input  logic [dctd_pkg::VALUE_W-1:0]  value,
	output logic                          count_valid,
	input  logic                          count_stall,
	output logic [dctd_pkg::COUNT_W-1:0]  divisor_count
);
	import dctd_pkg::*;

	state_t   state_q;
	word_t    v_q;
	word_t    d_q;
	exp_t     e_q;
	count_t   count_q;
	count_t   result_q;
	logic     out_valid_q;
	word_t    v_in;
	div_req_t req;
	div_rsp_t rsp;
	logic     load_out;

	assign v_in        = VALUE_BITS'(value);
	assign value_stall = (state_q != ST_IDLE);
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || !count_stall);

	assign req.start    = (state_q == ST_START);
	assign req.dividend = v_q;
	assign req.divisor  = d_q;

	dctd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (value_valid) begin
						e_q     <= '0;
						state_q <= (v_in == '0) ? ST_DONE : ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (rsp.done) begin
						if (e_q != '0) begin
							e_q     <= (rsp.remainder == '0) ? e_q + EXP_BITS'(1) : '0;
							state_q <= ST_START;
						end else if (d_q > rsp.quotient) begin
							state_q <= ST_DONE;
						end else begin
							if (rsp.remainder == '0) begin
								e_q <= EXP_BITS'(1);
							end
							state_q <= ST_START;
						end
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && value_valid) begin
			v_q     <= v_in;
			d_q     <= VALUE_BITS'(2);
			count_q <= (v_in == '0) ? '0 : COUNT_W'(1);
		end else if (state_q == ST_WAIT && rsp.done) begin
			if (e_q != '0) begin
				if (rsp.remainder == '0) begin
					v_q <= rsp.quotient;
				end else begin
					count_q <= sat_mul(count_q, e_q + EXP_BITS'(1));
					d_q     <= d_q + VALUE_BITS'(1);
				end
			end else if (d_q > rsp.quotient) begin
				if (v_q > VALUE_BITS'(1)) begin
					count_q <= sat_mul(count_q, EXP_BITS'(2));
				end
			end else if (rsp.remainder == '0) begin
				v_q <= rsp.quotient;
			end else begin
				d_q <= d_q + VALUE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!count_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= count_q;
		end
	end

	assign count_valid   = out_valid_q;
	assign divisor_count = result_q;

endmodule

>>> src/dctd_div.sv
// ----------------------------------------------------------------------------
// Divisor counter restoring divider
// Produces quotient and remainder one bit per cycle after a start pulse.
// ----------------------------------------------------------------------------
module dctd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dctd_pkg::div_req_t req,
	output dctd_pkg::div_rsp_t rsp
);
	import dctd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	word_t                rem_q;
	word_t                quo_q;
	word_t                dvs_q;
	logic [VALUE_BITS:0]  shifted;
	logic [VALUE_BITS:0]  diff;

	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_BITS'(1);
				if (step_q == STEP_BITS'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[VALUE_BITS]) begin
				rem_q <= diff[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VALUE_BITS-1:0];
				quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> src/dctd_chk.sv
// ----------------------------------------------------------------------------
// Divisor counter port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module dctd_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          value_valid,
	input logic                          value_stall,
	input logic [dctd_pkg::VALUE_W-1:0]  value,
	input logic                          count_valid,
	input logic                          count_stall,
	input logic [dctd_pkg::COUNT_W-1:0]  divisor_count
);

	// A waiting input transaction keeps its value until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && value_stall |=> value_valid && $stable(value))
		else $error("value changed while stalled");

	// A held result keeps its value until the transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		count_valid && count_stall |=> count_valid && $stable(divisor_count))
		else $error("divisor_count changed while stalled");

	// The block is busy in the cycle after it takes a transaction.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_stall |=> value_stall)
		else $error("input taken again right after a transaction");

	// A new result only appears right after the block was busy.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(count_valid) |-> $past(value_stall))
		else $error("result appeared without work in progress");

endmodule

bind divisor_count_trial_division dctd_chk u_dctd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.value_valid   (value_valid),
	.value_stall   (value_stall),
	.value         (value),
	.count_valid   (count_valid),
	.count_stall   (count_stall),
	.divisor_count (divisor_count)
);
